FILE: rtl/bmst_pkg.sv
// bmst_pkg: shared constants, codes and controller/datapath structs
// for the boruvka minimum spanning tree engine; depends on nothing
package bmst_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int WEIGHT_BITS_DEF  = 32;

    localparam int VTX_W  = 6;
    localparam int WGT_W  = 32;
    localparam int CFG_W  = 7;
    localparam int RANK_W = 3;

    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef enum logic [1:0] {
        CSEL_A,
        CSEL_B,
        CSEL_V
    } t_csel;

    typedef struct packed {
        logic  in_ready;
        logic  run_init;
        logic  clr_step;
        logic  round_init;
        logic  idx_inc;
        logic  edge_latch;
        logic  from_cheap;
        logic  find_step;
        logic  find_end_a;
        logic  find_end_b;
        t_csel csel;
        logic  cheap_wr;
        logic  merge_init;
        logic  vtx_inc;
        logic  join_q;
        logic  join_p;
        logic  emit;
        logic  finish;
        logic  st_set;
    } t_cmd;

    typedef struct packed {
        logic in_run;
        logic edge_oor;
        logic find_hit;
        logic roots_eq;
        logic cheap_better;
        logic vtx_valid;
        logic vtx_end;
        logic clr_end;
        logic idx_end;
        logic tcount_gt1;
        logic merged;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/bmst_if.sv
// bmst_in_if / bmst_out_if: valid-ready channels for edge words and tree words
// depends on bmst_pkg
interface bmst_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [bmst_pkg::VTX_W-1:0]          src_vertex;
    logic [bmst_pkg::VTX_W-1:0]          dst_vertex;
    logic signed [bmst_pkg::WGT_W-1:0]   edge_weight;

    modport source (output valid, func, src_vertex, dst_vertex, edge_weight, input ready);
    modport sink   (input valid, func, src_vertex, dst_vertex, edge_weight, output ready);
endinterface

interface bmst_out_if;
    logic                                valid;
    logic                                ready;
    logic [bmst_pkg::VTX_W-1:0]          tree_src;
    logic [bmst_pkg::VTX_W-1:0]          tree_dst;
    logic signed [bmst_pkg::WGT_W-1:0]   tree_weight;
    logic                                edge_valid;
    logic                                last;
    logic                                status;

    modport source (output valid, tree_src, tree_dst, tree_weight, edge_valid, last, status,
                     input ready);
    modport sink   (input valid, tree_src, tree_dst, tree_weight, edge_valid, last, status,
                     output ready);
endinterface

FILE: rtl/bmst_ram.sv
// bmst_ram: generic single write port ram with registered read
// no dependencies
module bmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bmst_ctrl.sv
// bmst_ctrl: sequencer for load, union-find clear, scan and merge rounds, emit
// depends on bmst_pkg
module bmst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmst_pkg::t_sts  i_sts,
    output bmst_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_RCHK, S_SRD, S_SWT, S_FAR, S_FAW, S_FBR, S_FBW,
        S_UPR, S_UPW, S_UQR, S_UQW, S_MCHK, S_MWT, S_JQ, S_JP, S_EMIT, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_mrg, n_mrg;
    bmst_pkg::t_cmd w_cmd;

    always_comb begin
        w_cmd   = '0;
        w_cmd.csel = bmst_pkg::CSEL_V;
        n_state = r_state;
        n_mrg   = r_mrg;
        case (r_state)
            S_IDLE: begin
                w_cmd.in_ready = 1'b1;
                if (i_sts.in_run) begin
                    w_cmd.run_init = 1'b1;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                w_cmd.clr_step = 1'b1;
                if (i_sts.clr_end) n_state = S_RCHK;
            end
            S_RCHK: begin
                if (i_sts.tcount_gt1) begin
                    w_cmd.round_init = 1'b1;
                    n_state = S_SRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SRD: begin
                if (i_sts.idx_end) begin
                    w_cmd.merge_init = 1'b1;
                    n_state = S_MCHK;
                end else begin
                    n_state = S_SWT;
                end
            end
            S_SWT: begin
                if (i_sts.edge_oor) begin
                    w_cmd.idx_inc = 1'b1;
                    n_state = S_SRD;
                end else begin
                    w_cmd.edge_latch = 1'b1;
                    n_mrg = 1'b0;
                    n_state = S_FAR;
                end
            end
            S_FAR: n_state = S_FAW;
            S_FAW: begin
                if (i_sts.find_hit) begin
                    w_cmd.find_end_a = 1'b1;
                    n_state = S_FBR;
                end else begin
                    w_cmd.find_step = 1'b1;
                    n_state = S_FAR;
                end
            end
            S_FBR: n_state = S_FBW;
            S_FBW: begin
                if (i_sts.find_hit) begin
                    w_cmd.find_end_b = 1'b1;
                    if (r_mrg) begin
                        if (i_sts.roots_eq) begin
                            w_cmd.vtx_inc = 1'b1;
                            n_state = S_MCHK;
                        end else begin
                            n_state = S_JQ;
                        end
                    end else begin
                        if (i_sts.roots_eq) begin
                            w_cmd.idx_inc = 1'b1;
                            n_state = S_SRD;
                        end else begin
                            n_state = S_UPR;
                        end
                    end
                end else begin
                    w_cmd.find_step = 1'b1;
                    n_state = S_FBR;
                end
            end
            S_UPR: begin
                w_cmd.csel = bmst_pkg::CSEL_A;
                n_state = S_UPW;
            end
            S_UPW: begin
                w_cmd.csel = bmst_pkg::CSEL_A;
                w_cmd.cheap_wr = i_sts.cheap_better;
                n_state = S_UQR;
            end
            S_UQR: begin
                w_cmd.csel = bmst_pkg::CSEL_B;
                n_state = S_UQW;
            end
            S_UQW: begin
                w_cmd.csel = bmst_pkg::CSEL_B;
                w_cmd.cheap_wr = i_sts.cheap_better;
                w_cmd.idx_inc = 1'b1;
                n_state = S_SRD;
            end
            S_MCHK: begin
                if (i_sts.vtx_end) begin
                    if (i_sts.merged) begin
                        n_state = S_RCHK;
                    end else begin
                        w_cmd.st_set = 1'b1;
                        n_state = S_FIN;
                    end
                end else if (!i_sts.vtx_valid) begin
                    w_cmd.vtx_inc = 1'b1;
                end else begin
                    n_state = S_MWT;
                end
            end
            S_MWT: begin
                w_cmd.edge_latch = 1'b1;
                w_cmd.from_cheap = 1'b1;
                n_mrg = 1'b1;
                n_state = S_FAR;
            end
            S_JQ: begin
                w_cmd.join_q = 1'b1;
                n_state = S_JP;
            end
            S_JP: begin
                w_cmd.join_p = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.vtx_inc = 1'b1;
                    n_state = S_MCHK;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    w_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mrg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mrg   <= n_mrg;
        end
    end

    assign o_cmd = w_cmd;

endmodule

FILE: rtl/bmst_dp.sv
// bmst_dp: edge store, union-find and cheapest tables, counters and output word
// depends on bmst_pkg, bmst_if, bmst_ram
module bmst_dp #(
    parameter int MAX_VERTICES = bmst_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bmst_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = bmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmst_pkg::t_cmd                i_cmd,
    output bmst_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [bmst_pkg::CFG_W-1:0]    i_cfg_data,
    bmst_in_if.sink                       i_edge,
    bmst_out_if.source                    o_tree
);

    localparam int VI_W = $clog2(MAX_VERTICES);
    localparam int VC_W = $clog2(MAX_VERTICES + 1);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int W    = WEIGHT_BITS;
    localparam int RW   = bmst_pkg::RANK_W;
    localparam int ED_W = 2 * VI_W + W;
    localparam int UF_W = VI_W + RW;
    localparam int OV_W = bmst_pkg::VTX_W;
    localparam int OW_W = bmst_pkg::WGT_W;
    localparam int CF_W = bmst_pkg::CFG_W;

    logic [EC_W-1:0]         r_ecount, r_idx;
    logic [VC_W-1:0]         r_vcount, r_vtx, r_tcount;
    logic [VI_W-1:0]         r_fx, r_root_a, r_root_b, r_ea, r_eb, r_pa, r_pb, r_oa, r_ob;
    logic [RW-1:0]           r_rank_a, r_rank_b;
    logic signed [W-1:0]     r_ew, r_pw, r_ow;
    logic [MAX_VERTICES-1:0] r_cvalid;
    logic                    r_merged, r_st, r_pv, r_ov, r_oev, r_olast, r_ost;

    logic [CF_W-1:0]     w_cfg;
    logic                w_load;
    logic [ED_W-1:0]     w_e_rd, w_c_rd, w_c_wd;
    logic [UF_W-1:0]     w_u_rd, w_u_wd;
    logic [VI_W-1:0]     w_e_a, w_e_b, w_c_a, w_c_b, w_u_par, w_c_addr, w_u_addr;
    logic [VI_W-1:0]     w_jp, w_jq;
    logic [RW-1:0]       w_u_rank, w_rk_p, w_rk_q;
    logic signed [W-1:0] w_e_w, w_c_w;
    logic                w_u_we, w_swap;

    // config saturation
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg = CF_W'(1);
        end else if (i_cfg_data > CF_W'(MAX_VERTICES)) begin
            w_cfg = CF_W'(MAX_VERTICES);
        end else begin
            w_cfg = i_cfg_data;
        end
    end

    assign i_edge.ready = i_cmd.in_ready;
    assign w_load = i_edge.valid && i_cmd.in_ready && (i_edge.func == bmst_pkg::FUNC_LOAD)
                    && ({1'b0, i_edge.src_vertex} < CF_W'(r_vcount))
                    && ({1'b0, i_edge.dst_vertex} < CF_W'(r_vcount))
                    && (r_ecount < EC_W'(MAX_EDGES));

    // edge store
    bmst_ram #(.WIDTH(ED_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_ecount[EA_W-1:0]),
        .i_wdata ({VI_W'(i_edge.src_vertex), VI_W'(i_edge.dst_vertex),
                   i_edge.edge_weight[W-1:0]}),
        .i_raddr (r_idx[EA_W-1:0]),
        .o_rdata (w_e_rd)
    );

    assign w_e_a = w_e_rd[ED_W-1 -: VI_W];
    assign w_e_b = w_e_rd[W +: VI_W];
    assign w_e_w = $signed(w_e_rd[W-1:0]);

    // union-find: parent and rank per vertex
    assign w_swap = r_rank_a < r_rank_b;
    assign w_jp   = w_swap ? r_root_b : r_root_a;
    assign w_jq   = w_swap ? r_root_a : r_root_b;
    assign w_rk_p = w_swap ? r_rank_b : r_rank_a;
    assign w_rk_q = w_swap ? r_rank_a : r_rank_b;

    always_comb begin
        w_u_we   = 1'b0;
        w_u_addr = w_jp;
        w_u_wd   = {w_jp, w_rk_p + RW'(1)};
        if (i_cmd.clr_step) begin
            w_u_we   = 1'b1;
            w_u_addr = r_vtx[VI_W-1:0];
            w_u_wd   = {r_vtx[VI_W-1:0], RW'(0)};
        end else if (i_cmd.join_q) begin
            w_u_we   = 1'b1;
            w_u_addr = w_jq;
            w_u_wd   = {w_jp, w_rk_q};
        end else if (i_cmd.join_p) begin
            w_u_we   = (w_rk_p == w_rk_q) && (w_rk_p != bmst_pkg::RANK_MAX);
        end
    end

    bmst_ram #(.WIDTH(UF_W), .DEPTH(MAX_VERTICES)) u_uf_ram (
        .i_clk   (i_clk),
        .i_we    (w_u_we),
        .i_waddr (w_u_addr),
        .i_wdata (w_u_wd),
        .i_raddr (r_fx),
        .o_rdata (w_u_rd)
    );

    assign w_u_par  = w_u_rd[UF_W-1 -: VI_W];
    assign w_u_rank = w_u_rd[RW-1:0];

    // cheapest edge per component
    always_comb begin
        case (i_cmd.csel)
            bmst_pkg::CSEL_A: w_c_addr = r_root_a;
            bmst_pkg::CSEL_B: w_c_addr = r_root_b;
            bmst_pkg::CSEL_V: w_c_addr = r_vtx[VI_W-1:0];
            default:          w_c_addr = r_vtx[VI_W-1:0];
        endcase
    end

    assign w_c_wd = {r_ea, r_eb, r_ew};

    bmst_ram #(.WIDTH(ED_W), .DEPTH(MAX_VERTICES)) u_cheap_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cheap_wr),
        .i_waddr (w_c_addr),
        .i_wdata (w_c_wd),
        .i_raddr (w_c_addr),
        .o_rdata (w_c_rd)
    );

    assign w_c_a = w_c_rd[ED_W-1 -: VI_W];
    assign w_c_b = w_c_rd[W +: VI_W];
    assign w_c_w = $signed(w_c_rd[W-1:0]);

    // status
    assign o_sts.in_run       = i_edge.valid && (i_edge.func == bmst_pkg::FUNC_RUN);
    assign o_sts.edge_oor     = (VC_W'(w_e_a) >= r_vcount) || (VC_W'(w_e_b) >= r_vcount);
    assign o_sts.find_hit     = (w_u_par == r_fx);
    assign o_sts.roots_eq     = (r_root_a == r_fx);
    assign o_sts.cheap_better = !r_cvalid[w_c_addr] || (r_ew < w_c_w);
    assign o_sts.vtx_valid    = r_cvalid[r_vtx[VI_W-1:0]];
    assign o_sts.vtx_end      = (r_vtx == r_vcount);
    assign o_sts.clr_end      = (r_vtx == VC_W'(MAX_VERTICES - 1));
    assign o_sts.idx_end      = (r_idx == r_ecount);
    assign o_sts.tcount_gt1   = (r_tcount > VC_W'(1));
    assign o_sts.merged       = r_merged;
    assign o_sts.pend_valid   = r_pv;
    assign o_sts.out_free     = !r_ov || o_tree.ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VC_W'(MAX_VERTICES);
            r_ecount <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) r_vcount <= VC_W'(w_cfg);
            if (w_load) r_ecount <= r_ecount + EC_W'(1);
            if (i_cmd.run_init) r_pv <= 1'b0;
            if (o_tree.ready && r_ov) r_ov <= 1'b0;
            if (i_cmd.emit) begin
                r_pv <= 1'b1;
                if (r_pv) r_ov <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_ov     <= 1'b1;
                r_pv     <= 1'b0;
                r_ecount <= '0;
            end
        end
    end

    // run state and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_vtx    <= '0;
            r_tcount <= r_vcount;
            r_st     <= 1'b0;
        end
        if (i_cmd.clr_step || i_cmd.vtx_inc) r_vtx <= r_vtx + VC_W'(1);
        if (i_cmd.merge_init) r_vtx <= '0;
        if (i_cmd.round_init) begin
            r_cvalid <= '0;
            r_merged <= 1'b0;
            r_idx    <= '0;
        end
        if (i_cmd.idx_inc) r_idx <= r_idx + EC_W'(1);
        if (i_cmd.cheap_wr) r_cvalid[w_c_addr] <= 1'b1;
        if (i_cmd.edge_latch) begin
            if (i_cmd.from_cheap) begin
                r_ea <= w_c_a;
                r_eb <= w_c_b;
                r_ew <= w_c_w;
                r_fx <= w_c_a;
            end else begin
                r_ea <= w_e_a;
                r_eb <= w_e_b;
                r_ew <= w_e_w;
                r_fx <= w_e_a;
            end
        end
        if (i_cmd.find_step) r_fx <= w_u_par;
        if (i_cmd.find_end_a) begin
            r_root_a <= r_fx;
            r_rank_a <= w_u_rank;
            r_fx     <= r_eb;
        end
        if (i_cmd.find_end_b) begin
            r_root_b <= r_fx;
            r_rank_b <= w_u_rank;
        end
        if (i_cmd.join_p) begin
            r_merged <= 1'b1;
            r_tcount <= r_tcount - VC_W'(1);
        end
        if (i_cmd.st_set) r_st <= 1'b1;
        if (i_cmd.emit) begin
            if (r_pv) begin
                r_oa    <= r_pa;
                r_ob    <= r_pb;
                r_ow    <= r_pw;
                r_oev   <= 1'b1;
                r_olast <= 1'b0;
                r_ost   <= 1'b0;
            end
            r_pa <= r_ea;
            r_pb <= r_eb;
            r_pw <= r_ew;
        end
        if (i_cmd.finish) begin
            r_oa    <= r_pv ? r_pa : '0;
            r_ob    <= r_pv ? r_pb : '0;
            r_ow    <= r_pv ? r_pw : '0;
            r_oev   <= r_pv;
            r_olast <= 1'b1;
            r_ost   <= r_st;
        end
    end

    assign o_tree.valid       = r_ov;
    assign o_tree.tree_src    = OV_W'(r_oa);
    assign o_tree.tree_dst    = OV_W'(r_ob);
    assign o_tree.tree_weight = OW_W'(r_ow);
    assign o_tree.edge_valid  = r_oev;
    assign o_tree.last        = r_olast;
    assign o_tree.status      = r_ost;

`ifndef SYNTHESIS
    a_ecount_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecount <= EC_W'(MAX_EDGES))
        else $error("edge count above capacity");
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_pv) |=> r_ov)
        else $error("pending edge not moved to output");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_oev) |-> r_olast)
        else $error("empty word without last");
    a_cheap_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cheap_wr |=> r_cvalid[$past(w_c_addr)])
        else $error("cheapest entry written but not marked");
    a_join_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.join_p |-> (r_tcount > VC_W'(1)))
        else $error("merge with a single component left");
`endif

endmodule

FILE: rtl/boruvka_minimum_spanning_tree.sv
// boruvka_minimum_spanning_tree: top level, controller plus datapath
// depends on bmst_pkg, bmst_if, bmst_ram, bmst_ctrl, bmst_dp
//
// Load words (func 0) are taken one per cycle while idle and appended to the edge
// store; edges with an endpoint not below vertex_count, or beyond MAX_EDGES, are
// dropped. A run word (func 1) blocks the input until the last tree word has been
// loaded into the output register: it starts with a clearing pass over all
// MAX_VERTICES entries of the parent/rank memory, then each round scans the stored
// edges (a read per edge, root walks of both endpoints of an in-range edge, and the
// cheapest table update of both roots of a cross edge) and walks the components
// (skip a vertex with no cheapest edge, else walk and join its chosen edge, plus any
// wait for the output). Everything is paced by the single read port of the parent
// memory. Tree words come out in merge order, the last one flagged with last and
// status (1 when the graph is disconnected); a run with no tree edge gives one word
// with edge_valid 0. The run empties the edge store.
module boruvka_minimum_spanning_tree #(
    parameter int MAX_VERTICES = bmst_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bmst_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = bmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bmst_pkg::CFG_W-1:0]  i_cfg_data,
    bmst_in_if.sink                     i_edge,
    bmst_out_if.source                  o_tree
);

    bmst_pkg::t_cmd w_cmd;
    bmst_pkg::t_sts w_sts;

    bmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bmst_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_edge     (i_edge),
        .o_tree     (o_tree)
    );

endmodule
